// ===== rtl/line_rasterizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// line_rasterizer_top_defines.svh
// Assertion macros used by the line rasterizer top level.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_TOP_DEFINES_SVH
`define LINE_RASTERIZER_TOP_DEFINES_SVH

// Check that cond implies res in the same cycle, clocked on clk, off in reset.
`define LR_ASSERT_SAME(lbl, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (res)) \
    else $error("line rasterizer check failed");

// Check that cond implies res in the following cycle, clocked on clk, off in reset.
`define LR_ASSERT_NEXT(lbl, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) \
    else $error("line rasterizer check failed");

`endif

// ===== rtl/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// lr_pkg
// Types and constants shared by the line rasterizer modules.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Field widths
  localparam int COORD_W    = 9;
  localparam int ERR_W      = 11;
  localparam int COLOR_W    = 16;
  localparam int PIX_Y_W    = 8;
  localparam int OFFSET_W   = 18;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Command queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Item kinds carried on tuser
  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } lr_kind_t;

  // Classified command passed from the front end to the drawing engine
  typedef struct packed {
    lr_kind_t             kind;
    logic                 steep;
    logic                 minor_down;
    logic [COORD_W-1:0]   major_pos;
    logic [COORD_W-1:0]   minor_pos;
    logic [COORD_W-1:0]   major_end;
    logic [COORD_W-1:0]   major_delta;
    logic [COORD_W-1:0]   minor_delta;
    logic [COLOR_W-1:0]   color;
  } lr_cmd_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic active;
    logic emit;
    logic emit_last;
  } lr_stat_t;

endpackage

// ===== rtl/lr_front.sv =====
// ----------------------------------------------------------------------------
// lr_front
// Accepts input beats and classifies start items: octant, endpoint order
// and deltas, ready to push into the command queue.
// ----------------------------------------------------------------------------
module lr_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lr_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                         s_tuser,
  input  logic                         q_full,
  output logic                         q_push,
  output lr_pkg::lr_cmd_t              q_cmd
);
  import lr_pkg::*;

  logic [COORD_W-1:0] xa, ya, xb, yb;
  logic [COORD_W-1:0] dx, dy;
  logic               steep;
  logic [COORD_W-1:0] ma, na, mb, nb;
  logic [COORD_W-1:0] m_lo, n_lo, m_hi, n_hi;

  // Take a beat whenever the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Unpack endpoints
  assign xa = s_tdata[8:0];
  assign ya = s_tdata[17:9];
  assign xb = s_tdata[26:18];
  assign yb = s_tdata[35:27];

  // Pick the major axis and order endpoints along it
  always_comb begin
    dx    = (xa > xb) ? (xa - xb) : (xb - xa);
    dy    = (ya > yb) ? (ya - yb) : (yb - ya);
    steep = dy > dx;
    if (steep) begin
      ma = ya; na = xa; mb = yb; nb = xb;
    end else begin
      ma = xa; na = ya; mb = xb; nb = yb;
    end
    if (ma > mb) begin
      m_lo = mb; n_lo = nb; m_hi = ma; n_hi = na;
    end else begin
      m_lo = ma; n_lo = na; m_hi = mb; n_hi = nb;
    end
  end

  // Build the queued command
  always_comb begin
    q_cmd.kind        = lr_kind_t'(s_tuser);
    q_cmd.steep       = steep;
    q_cmd.minor_down  = n_lo > n_hi;
    q_cmd.major_pos   = m_lo;
    q_cmd.minor_pos   = n_lo;
    q_cmd.major_end   = m_hi;
    q_cmd.major_delta = m_hi - m_lo;
    q_cmd.minor_delta = (n_lo > n_hi) ? (n_lo - n_hi) : (n_hi - n_lo);
    q_cmd.color       = s_tdata[51:36];
  end

endmodule

// ===== rtl/lr_queue.sv =====
// ----------------------------------------------------------------------------
// lr_queue
// Two-entry command queue between the front end and the drawing engine.
// ----------------------------------------------------------------------------
module lr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lr_pkg::lr_cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lr_pkg::lr_cmd_t head_cmd
);
  import lr_pkg::*;

  lr_cmd_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic [Q_CNT_W-1:0]   count_next;

  assign full       = count == Q_CNT_W'(Q_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];

  always_comb begin
    count_next = count + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/lr_back.sv =====
// ----------------------------------------------------------------------------
// lr_back
// Drawing engine: holds the running line, steps Bresenham once per step
// command and registers each pixel into the output stage.
// ----------------------------------------------------------------------------
module lr_back #(
  parameter int X_BITS    = 9,
  parameter int Y_BITS    = 8,
  parameter int ROW_SHIFT = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  lr_pkg::lr_cmd_t               q_cmd,
  output logic                          q_pop,
  output lr_pkg::lr_stat_t              stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import lr_pkg::*;

  localparam logic [COORD_W-1:0] XMASK = COORD_W'((1 << X_BITS) - 1);
  localparam logic [COORD_W-1:0] YMASK = COORD_W'((1 << Y_BITS) - 1);
  localparam int                 SUM_W = COORD_W + ROW_SHIFT + 1;
  localparam int                 PAD_W = OUT_DATA_W - COORD_W - PIX_Y_W - COLOR_W - OFFSET_W;

  // Line state
  logic                       active;
  logic                       steep;
  logic                       minor_down;
  logic [COORD_W-1:0]         major_pos;
  logic [COORD_W-1:0]         minor_pos;
  logic [COORD_W-1:0]         major_end;
  logic [COORD_W-1:0]         major_delta;
  logic [COORD_W-1:0]         minor_delta;
  logic [ERR_W-1:0]           error_term;
  logic [COLOR_W-1:0]         held_color;

  // Output stage
  logic [COORD_W-1:0]         pixel_x;
  logic [PIX_Y_W-1:0]         pixel_y;
  logic [COLOR_W-1:0]         pixel_color;
  logic [OFFSET_W-1:0]        byte_offset;

  logic                       out_free;
  logic                       is_start;
  logic                       emit;
  logic                       last;
  logic [COORD_W-1:0]         xm, ym;
  logic [SUM_W-1:0]           offset_sum;
  logic [ERR_W-1:0]           err_sum;
  logic                       minor_move;
  logic [ERR_W-1:0]           error_term_next;
  logic [COORD_W-1:0]         minor_pos_next;

  // Decide what to do with the queue head
  assign out_free = !m_tvalid || m_tready;
  assign is_start = q_valid && (q_cmd.kind == KIND_START);
  assign emit     = q_valid && (q_cmd.kind == KIND_STEP) && active && out_free;
  assign q_pop    = q_valid && ((q_cmd.kind == KIND_START) || !active || out_free);
  assign last     = major_pos == major_end;

  assign stat.active    = active;
  assign stat.emit      = emit;
  assign stat.emit_last = emit && last;

  // Map back to screen axes and form the framebuffer offset
  always_comb begin
    xm = (steep ? minor_pos : major_pos) & XMASK;
    ym = (steep ? major_pos : minor_pos) & YMASK;
    offset_sum = (SUM_W'(ym) << ROW_SHIFT) + (SUM_W'(xm) << 1);
  end

  // Error update: move the minor axis when the sum goes positive
  always_comb begin
    err_sum         = error_term + ERR_W'(minor_delta);
    minor_move      = !err_sum[ERR_W-1] && (err_sum != '0);
    error_term_next = minor_move ? (err_sum - ERR_W'(major_delta)) : err_sum;
    if (!minor_move) begin
      minor_pos_next = minor_pos;
    end else if (minor_down) begin
      minor_pos_next = minor_pos - 1'b1;
    end else begin
      minor_pos_next = minor_pos + 1'b1;
    end
  end

  // Load a new line or advance the running one
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      steep       <= 1'b0;
      minor_down  <= 1'b0;
      major_pos   <= '0;
      minor_pos   <= '0;
      major_end   <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      error_term  <= '0;
      held_color  <= '0;
    end else if (is_start) begin
      active      <= 1'b1;
      steep       <= q_cmd.steep;
      minor_down  <= q_cmd.minor_down;
      major_pos   <= q_cmd.major_pos;
      minor_pos   <= q_cmd.minor_pos;
      major_end   <= q_cmd.major_end;
      major_delta <= q_cmd.major_delta;
      minor_delta <= q_cmd.minor_delta;
      error_term  <= '0 - ERR_W'(q_cmd.major_delta[COORD_W-1:1]);
      held_color  <= q_cmd.color;
    end else if (emit) begin
      if (last) begin
        active <= 1'b0;
      end else begin
        error_term <= error_term_next;
        minor_pos  <= minor_pos_next;
        major_pos  <= major_pos + 1'b1;
      end
    end
  end

  // Output valid: set on a new pixel, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x     <= xm;
      pixel_y     <= ym[PIX_Y_W-1:0];
      pixel_color <= held_color;
      byte_offset <= OFFSET_W'(offset_sum);
      m_tlast     <= last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, byte_offset, pixel_color, pixel_y, pixel_x};

endmodule

// ===== rtl/line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer_top
// Bresenham line generator: start beats load a line, step beats emit pixels.
// ----------------------------------------------------------------------------
// Input channel (s_*): s_tuser selects the beat kind, 0 start, 1 step. A start
// beat loads both endpoints and the color and produces nothing; each step
// beat produces one pixel while a line is running, and none when idle.
// Output channel (m_*): one beat per pixel with x, y, color and framebuffer
// byte offset; m_tlast marks the final pixel, after which the block is idle.
// A start beat during a running line abandons it and loads the new one.
// A step beat is queued, then its pixel is registered into the output stage.
// Throughput: one beat per cycle sustained while m_tready stays high; each pixel
// costs one add, compare and subtract on the error term in the drawing engine.
// Reset (rst, synchronous) empties the two-entry command queue, drops
// m_tvalid and leaves the engine idle.
// When the receiver stalls, the output register holds its pixel, step beats for
// a running line collect in the queue, and once it holds two, s_tready falls.
// ----------------------------------------------------------------------------
`include "line_rasterizer_top_defines.svh"

module line_rasterizer_top #(
  parameter int X_BITS    = 9,
  parameter int Y_BITS    = 8,
  parameter int ROW_SHIFT = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27], line_color[51:36]
  input  logic [lr_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind[0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pixel_x[8:0], pixel_y[16:9], pixel_color[32:17], byte_offset[50:33]
  output logic [lr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import lr_pkg::*;

  logic     q_full;
  logic     q_push;
  lr_cmd_t  push_cmd;
  logic     q_pop;
  logic     q_valid;
  lr_cmd_t  head_cmd;
  lr_stat_t stat;

  lr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  lr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  lr_back #(
    .X_BITS    (X_BITS),
    .Y_BITS    (Y_BITS),
    .ROW_SHIFT (ROW_SHIFT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A full queue always presents a command to the engine
  `LR_ASSERT_SAME(a_full_has_head, !s_tready, q_valid)
  // A start command leaves a running line behind
  `LR_ASSERT_NEXT(a_start_loads, q_pop && (head_cmd.kind == KIND_START), stat.active)
  // Every emitted pixel lands in the output register
  `LR_ASSERT_NEXT(a_emit_shows, stat.emit, m_tvalid)
  // The final pixel returns the engine to idle
  `LR_ASSERT_NEXT(a_last_idles, stat.emit_last, !stat.active)

endmodule

// ===== tb/line_rasterizer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_top_tb
// Self-checking bench for the Bresenham line generator.
// ----------------------------------------------------------------------------
// Start and step beats are queued up front and fed through the input stream
// with random gaps, while the pixel stream sees random back-pressure. Every
// accepted beat runs through a local line tracer that rebuilds the pixel the
// block should emit; emitted pixels are matched in order against that list.
// ----------------------------------------------------------------------------
module line_rasterizer_top_tb;
  import lr_pkg::*;

  localparam int ROW_SHIFT    = 10;
  localparam int COORD_MAX    = 511;
  localparam int STIM_ITEMS   = 1600;
  localparam int QUIET_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SHOW_MAX     = 10;

  typedef struct packed {
    lr_kind_t             kind;
    logic [COORD_W-1:0]   xs;
    logic [COORD_W-1:0]   ys;
    logic [COORD_W-1:0]   xe;
    logic [COORD_W-1:0]   ye;
    logic [COLOR_W-1:0]   color;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0]   px;
    logic [PIX_Y_W-1:0]   py;
    logic [COLOR_W-1:0]   color;
    logic [OFFSET_W-1:0]  offset;
    logic                 last;
  } pixel_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = KIND_START;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  line_rasterizer_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  line_cmd_t cmd_q[$];
  pixel_t    pixel_q[$];
  int        mismatch_cnt = 0;
  int        cycle_cnt    = 0;
  int        stim_cnt     = 0;
  int        gen_left     = 0;
  bit        beat_taken   = 1'b0;
  bit        calm         = 1'b0;
  int        src_gap      = 0;
  int        sink_stall   = 0;

  // Line tracer state
  bit                        ln_active;
  bit                        ln_steep;
  bit                        ln_down;
  logic [COORD_W-1:0]        ln_major;
  logic [COORD_W-1:0]        ln_minor;
  logic [COORD_W-1:0]        ln_major_end;
  logic [COORD_W-1:0]        ln_major_delta;
  logic [COORD_W-1:0]        ln_minor_delta;
  logic signed [ERR_W-1:0]   ln_err;
  logic [COLOR_W-1:0]        ln_color;

  function automatic void trace_reset();
    ln_active      = 1'b0;
    ln_steep       = 1'b0;
    ln_down        = 1'b0;
    ln_major       = '0;
    ln_minor       = '0;
    ln_major_end   = '0;
    ln_major_delta = '0;
    ln_minor_delta = '0;
    ln_err         = '0;
    ln_color       = '0;
  endfunction

  // Apply one beat to the tracer; return 1 when it produces a pixel.
  function automatic bit trace_beat(input line_cmd_t c, output pixel_t p);
    logic [COORD_W-1:0] dx, dy, ma, na, mb, nb, px, py;
    bit                 last;
    p = '0;
    if (c.kind == KIND_START) begin
      dx = (c.xs > c.xe) ? c.xs - c.xe : c.xe - c.xs;
      dy = (c.ys > c.ye) ? c.ys - c.ye : c.ye - c.ys;
      ln_steep = dy > dx;
      if (ln_steep) begin
        ma = c.ys; na = c.xs; mb = c.ye; nb = c.xe;
      end else begin
        ma = c.xs; na = c.ys; mb = c.xe; nb = c.ye;
      end
      // order the endpoints so the major coordinate climbs
      if (ma > mb) begin
        {ma, mb} = {mb, ma};
        {na, nb} = {nb, na};
      end
      ln_major       = ma;
      ln_minor       = na;
      ln_major_end   = mb;
      ln_major_delta = mb - ma;
      ln_minor_delta = (na > nb) ? na - nb : nb - na;
      ln_down        = na > nb;
      ln_err         = -$signed({2'b00, ln_major_delta >> 1});
      ln_color       = c.color;
      ln_active      = 1'b1;
      return 1'b0;
    end
    if (!ln_active)
      return 1'b0;
    px = ln_steep ? ln_minor : ln_major;
    py = ln_steep ? ln_major : ln_minor;
    last = (ln_major == ln_major_end);
    p.px     = px;
    p.py     = py[PIX_Y_W-1:0];
    p.color  = ln_color;
    p.offset = (OFFSET_W'(py[PIX_Y_W-1:0]) << ROW_SHIFT) + (OFFSET_W'(px) << 1);
    p.last   = last;
    if (last) begin
      ln_active = 1'b0;
    end else begin
      ln_err = ln_err + $signed({2'b00, ln_minor_delta});
      if (ln_err > 0) begin
        ln_minor = ln_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
        ln_err   = ln_err - $signed({2'b00, ln_major_delta});
      end
      ln_major = ln_major + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(508, 511);
    return $urandom_range(0, COORD_MAX);
  endfunction

  function automatic void push_start(input int xs, input int ys, input int xe, input int ye,
                                     input int color);
    line_cmd_t c;
    int        dx, dy;
    c.kind  = KIND_START;
    c.xs    = COORD_W'(xs);
    c.ys    = COORD_W'(ys);
    c.xe    = COORD_W'(xe);
    c.ye    = COORD_W'(ye);
    c.color = COLOR_W'(color);
    cmd_q.push_back(c);
    dx = (xs > xe) ? xs - xe : xe - xs;
    dy = (ys > ye) ? ys - ye : ye - ys;
    gen_left = ((dx > dy) ? dx : dy) + 1;
    stim_cnt++;
  endfunction

  // Step beats carry random filler in the unused data fields.
  function automatic void push_steps(input int n);
    line_cmd_t c;
    for (int i = 0; i < n; i++) begin
      c = line_cmd_t'($bits(line_cmd_t)'({$urandom, $urandom}));
      c.kind = KIND_STEP;
      cmd_q.push_back(c);
      if (gen_left > 0) begin
        gen_left--;
        stim_cnt++;
      end
    end
  endfunction

  // Stimulus, reset and end of run
  initial begin
    int xs, ys, xe, ye, len, roll;
    trace_reset();

    // directed lines
    push_steps(1);                               // step with no line loaded
    push_start(0, 0, 0, 0, 16'h0000);            // single point
    push_steps(2);
    push_start(511, 511, 0, 0, 16'hFFFF);        // extreme diagonal, reversed
    push_steps(3);
    push_start(0, 511, 511, 0, 16'hAAAA);        // abandons the running line
    push_steps(2);
    push_start(3, 7, 5, 7, 16'h5555);            // horizontal
    push_steps(3);
    push_start(9, 300, 9, 297, 16'h1234);        // vertical, steep, reversed
    push_steps(4);
    push_start(10, 20, 14, 18, 16'hBEEF);        // shallow, minor axis falling
    push_steps(5);

    // random lines, mostly well formed
    while (stim_cnt < STIM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        xs = pick_coord();
        ys = pick_coord();
        if (roll < 4) begin
          xe = $urandom_range(0, COORD_MAX);
          ye = $urandom_range(0, COORD_MAX);
        end else begin
          xe = clamp_coord(xs + $urandom_range(0, 24) - 12);
          ye = clamp_coord(ys + $urandom_range(0, 24) - 12);
        end
        push_start(xs, ys, xe, ye, $urandom_range(0, 16'hFFFF));
        len = gen_left;
        case ($urandom_range(0, 9))
          0: push_steps($urandom_range(0, len - 1));
          1: push_steps(len + $urandom_range(1, 3));
          default: push_steps(len);
        endcase
      end else if (roll < 93) begin
        push_start($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, 16'hFFFF));
        push_steps($urandom_range(0, 6));
      end else begin
        push_steps($urandom_range(1, 4));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || s_tvalid)
      @(posedge clk);
    while (pixel_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Drive both streams on the falling edge
  always @(negedge clk) begin
    line_cmd_t nxt;
    bit        no_idle;
    if (rst) begin
      s_tvalid   <= 1'b0;
      m_tready   <= 1'b0;
      beat_taken = 1'b0;
      src_gap    = 0;
      sink_stall = 0;
    end else begin
      if (cycle_cnt % 128 == 0)
        calm = ($urandom_range(0, 3) == 0);
      no_idle = calm || (cmd_q.size() < QUIET_ITEMS);

      // advance the input beat once the current one is taken
      if (!s_tvalid || beat_taken) begin
        beat_taken = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          nxt = cmd_q.pop_front();
          s_tdata  <= {4'b0, nxt.color, nxt.ye, nxt.xe, nxt.ys, nxt.xs};
          s_tuser  <= nxt.kind;
          s_tvalid <= 1'b1;
          if (!no_idle && $urandom_range(0, 5) == 0)
            src_gap = $urandom_range(1, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end

      // random back-pressure on the pixel stream
      if (sink_stall == 0 && !no_idle && $urandom_range(0, 9) == 0)
        sink_stall = $urandom_range(1, 9);
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Sample beats on the rising edge, predict and check
  always @(posedge clk) begin
    line_cmd_t c;
    pixel_t    pix, got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        beat_taken = 1'b1;
        c.kind  = lr_kind_t'(s_tuser);
        c.xs    = s_tdata[8:0];
        c.ys    = s_tdata[17:9];
        c.xe    = s_tdata[26:18];
        c.ye    = s_tdata[35:27];
        c.color = s_tdata[51:36];
        if (trace_beat(c, pix))
          pixel_q.push_back(pix);
      end
      if (m_tvalid && m_tready) begin
        got.px     = m_tdata[8:0];
        got.py     = m_tdata[16:9];
        got.color  = m_tdata[32:17];
        got.offset = m_tdata[50:33];
        got.last   = m_tlast;
        if (pixel_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOW_MAX)
            $display("%0t: unexpected pixel x=%0d y=%0d color=%h off=%h last=%0b",
                     $realtime, got.px, got.py, got.color, got.offset, got.last);
        end else begin
          want = pixel_q.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.color !== want.color ||
              got.offset !== want.offset || got.last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOW_MAX) begin
              $display("%0t: pixel mismatch", $realtime);
              $display("  expected x=%0d y=%0d color=%h off=%h last=%0b",
                       want.px, want.py, want.color, want.offset, want.last);
              $display("  actual   x=%0d y=%0d color=%h off=%h last=%0b",
                       got.px, got.py, got.color, got.offset, got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_front.sv
rtl/lr_queue.sv
rtl/lr_back.sv
rtl/line_rasterizer_top.sv
tb/line_rasterizer_top_tb.sv
